FILE: hdl/swk_pkg.sv
// Shared types, constants and helpers for the swerve wheel kinematics pipeline.
// No dependencies.
package swk_pkg;

  localparam int WHEELS   = 4;
  localparam int IN_W     = 16;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 2;
  localparam int AB_W     = 33;
  localparam int MAG_W    = 32;
  localparam int SQ_W     = 64;
  localparam int SPD_W    = 32;
  localparam int ANG_W    = 15;
  localparam int DRV_W    = 15;
  localparam int NRM_W    = 34;
  localparam int CX_W     = 36;
  localparam int Z_W      = 26;
  localparam int ANGLE_LIMIT = 11520;
  localparam int Z_QUARTER   = 90 * 65536;
  localparam int CFG_RESET   = 4096;

  localparam logic [SQ_W-1:0] SQ_LIMIT = 64'h0040_0000_0000_0000;

  // wheel pairs: sine operand (P) and cosine operand (Q); sides are a, b, c, d
  localparam int P_SEL [WHEELS] = '{1, 1, 0, 0};
  localparam int Q_SEL [WHEELS] = '{3, 2, 3, 2};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WHEEL_BASE  = 2'd0,
    REG_TRACK_WIDTH = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic valid;
    logic limited;
  } ctl_t;

  typedef logic [WHEELS-1:0][AB_W-1:0]  side_vec_t;
  typedef logic [WHEELS-1:0][SQ_W-1:0]  sq_vec_t;
  typedef logic [WHEELS-1:0][SPD_W-1:0] spd_vec_t;
  typedef logic [WHEELS-1:0][ANG_W-1:0] ang_vec_t;
  typedef logic [WHEELS-1:0][DRV_W-1:0] drv_vec_t;

  function automatic logic [MAG_W-1:0] mag_of(input logic [AB_W-1:0] v);
    logic [AB_W-1:0] n;
    n = v[AB_W-1] ? (~v + 1'b1) : v;
    return n[MAG_W-1:0];
  endfunction

  // atan(2^-i) in 2^-16 degree
  function automatic logic signed [Z_W-1:0] atan_step(input int i);
    logic signed [Z_W-1:0] r;
    case (i)
      0:  r = Z_W'(2949120);
      1:  r = Z_W'(1740967);
      2:  r = Z_W'(919879);
      3:  r = Z_W'(466945);
      4:  r = Z_W'(234379);
      5:  r = Z_W'(117304);
      6:  r = Z_W'(58666);
      7:  r = Z_W'(29335);
      8:  r = Z_W'(14668);
      9:  r = Z_W'(7334);
      10: r = Z_W'(3667);
      11: r = Z_W'(1833);
      12: r = Z_W'(917);
      13: r = Z_W'(458);
      14: r = Z_W'(229);
      15: r = Z_W'(115);
      16: r = Z_W'(57);
      17: r = Z_W'(29);
      18: r = Z_W'(14);
      19: r = Z_W'(7);
      20: r = Z_W'(4);
      21: r = Z_W'(2);
      22: r = Z_W'(1);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

FILE: hdl/swk_front.sv
// Front end: wheel side terms A..D, their squares and per-wheel sums of squares.
// Depends on swk_pkg.
module swk_front import swk_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    in_valid,
  input  logic signed [IN_W-1:0]  vel_x,
  input  logic signed [IN_W-1:0]  vel_y,
  input  logic signed [IN_W-1:0]  turn_rate,
  input  logic [CFG_W-1:0]        wheel_base,
  input  logic [CFG_W-1:0]        track_width,
  output ctl_t                    ctl_o,
  output side_vec_t               side_o,
  output sq_vec_t                 sq_o
);

  logic                   v1, v2, v3;
  logic signed [IN_W-1:0] x1, y1;
  logic signed [AB_W-1:0] wb1, wt1;
  side_vec_t              side2, side3;
  sq_vec_t                sqr3;
  logic [AB_W-1:0]        xs, ys;
  sq_vec_t                sum_c;
  logic                   lim_c;
  logic [SQ_W:0]          s;

  assign xs = {{4{x1[IN_W-1]}}, x1, 13'b0};
  assign ys = {{4{y1[IN_W-1]}}, y1, 13'b0};

  always_comb begin
    lim_c = 1'b0;
    s = '0;
    for (int w = 0; w < WHEELS; w++) begin
      s = {1'b0, sqr3[P_SEL[w]]} + {1'b0, sqr3[Q_SEL[w]]};
      sum_c[w] = s[SQ_W-1:0];
      lim_c = lim_c | (s[SQ_W-1:0] > SQ_LIMIT);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      ctl_o <= '0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      ctl_o.valid <= v3;
      ctl_o.limited <= lim_c;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1 <= vel_x;
      y1 <= vel_y;
      wb1 <= turn_rate * $signed({1'b0, wheel_base});
      wt1 <= turn_rate * $signed({1'b0, track_width});
      side2[0] <= $signed(xs) + wb1;
      side2[1] <= $signed(xs) - wb1;
      side2[2] <= $signed(ys) + wt1;
      side2[3] <= $signed(ys) - wt1;
      side3 <= side2;
      for (int k = 0; k < WHEELS; k++) begin
        sqr3[k] <= mag_of(side2[k]) * mag_of(side2[k]);
      end
      side_o <= side3;
      sq_o <= sum_c;
    end
  end

endmodule

FILE: hdl/swk_sqrt.sv
// Pipelined integer square root, one root bit per stage, four lanes.
// Depends on swk_pkg.
module swk_sqrt import swk_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      en,
  input  ctl_t      ctl_i,
  input  side_vec_t side_i,
  input  sq_vec_t   sq_i,
  output ctl_t      ctl_o,
  output side_vec_t side_o,
  output spd_vec_t  spd_o
);

  localparam int STEPS = SPD_W;
  localparam int REM_W = SPD_W + 2;
  localparam int TRY_W = SPD_W + 4;

  ctl_t                        ctl_q  [STEPS];
  side_vec_t                   side_q [STEPS];
  sq_vec_t                     val_q  [STEPS];
  logic [WHEELS-1:0][REM_W-1:0] rem_q [STEPS];
  spd_vec_t                    root_q [STEPS];

  for (genvar s = 0; s < STEPS; s++) begin : g_stage
    ctl_t                         ctl_in;
    side_vec_t                    side_in;
    sq_vec_t                      val_in, val_nx;
    logic [WHEELS-1:0][REM_W-1:0] rem_in, rem_nx;
    spd_vec_t                     root_in, root_nx;
    logic [WHEELS-1:0][TRY_W-1:0] rem_t, trial;

    if (s == 0) begin : g_first
      assign ctl_in  = ctl_i;
      assign side_in = side_i;
      assign val_in  = sq_i;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_rest
      assign ctl_in  = ctl_q[s-1];
      assign side_in = side_q[s-1];
      assign val_in  = val_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign root_in = root_q[s-1];
    end

    always_comb begin
      for (int w = 0; w < WHEELS; w++) begin
        rem_t[w] = {rem_in[w], val_in[w][SQ_W-1 -: 2]};
        trial[w] = {2'b00, root_in[w], 2'b01};
        val_nx[w] = {val_in[w][SQ_W-3:0], 2'b00};
        if (rem_t[w] >= trial[w]) begin
          rem_nx[w] = REM_W'(rem_t[w] - trial[w]);
          root_nx[w] = {root_in[w][SPD_W-2:0], 1'b1};
        end else begin
          rem_nx[w] = REM_W'(rem_t[w]);
          root_nx[w] = {root_in[w][SPD_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        ctl_q[s] <= '0;
      end else if (en) begin
        ctl_q[s] <= ctl_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        side_q[s] <= side_in;
        val_q[s] <= val_nx;
        rem_q[s] <= rem_nx;
        root_q[s] <= root_nx;
      end
    end
  end

  assign ctl_o  = ctl_q[STEPS-1];
  assign side_o = side_q[STEPS-1];
  assign spd_o  = root_q[STEPS-1];

endmodule

FILE: hdl/swk_cordic.sv
// Pipelined vectoring CORDIC: normalize, quadrant fold, rotate, round to 1/64 degree.
// Depends on swk_pkg.
module swk_cordic import swk_pkg::*; #(
  parameter int STEPS = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      en,
  input  ctl_t      ctl_i,
  input  side_vec_t side_i,
  input  spd_vec_t  spd_i,
  output ctl_t      ctl_o,
  output spd_vec_t  spd_o,
  output ang_vec_t  ang_o
);

  localparam int NORM_N = 6;
  localparam int M_W    = MAG_W + 1;
  localparam int LAT    = NORM_N + STEPS + 3;

  ctl_t                          ctl_q  [LAT];
  spd_vec_t                      spd_q  [LAT];
  logic [WHEELS-1:0]             zero_q [LAT];
  logic [WHEELS-1:0][NRM_W-1:0]  nx_q   [NORM_N+1];
  logic [WHEELS-1:0][NRM_W-1:0]  ny_q   [NORM_N+1];
  logic [WHEELS-1:0][M_W-1:0]    nm_q   [NORM_N+1];
  logic [WHEELS-1:0][CX_W-1:0]   cx_q   [STEPS+1];
  logic [WHEELS-1:0][CX_W-1:0]   cy_q   [STEPS+1];
  logic [WHEELS-1:0][Z_W-1:0]    cz_q   [STEPS+1];
  ang_vec_t                      ang_q;
  logic [WHEELS-1:0]             zero_c;

  // payload and zero-vector flag ride along
  for (genvar s = 0; s < LAT; s++) begin : g_pay
    if (s == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (rst) begin
          ctl_q[s] <= '0;
        end else if (en) begin
          ctl_q[s] <= ctl_i;
        end
      end
      always_ff @(posedge clk) begin
        if (en) begin
          spd_q[s] <= spd_i;
          zero_q[s] <= zero_c;
        end
      end
    end else begin : g_rest
      always_ff @(posedge clk) begin
        if (rst) begin
          ctl_q[s] <= '0;
        end else if (en) begin
          ctl_q[s] <= ctl_q[s-1];
        end
      end
      always_ff @(posedge clk) begin
        if (en) begin
          spd_q[s] <= spd_q[s-1];
          zero_q[s] <= zero_q[s-1];
        end
      end
    end
  end

  // operand pick, zero-vector test
  always_comb begin
    logic [AB_W-1:0] p, q;
    for (int w = 0; w < WHEELS; w++) begin
      p = side_i[P_SEL[w]];
      q = side_i[Q_SEL[w]];
      zero_c[w] = (p == '0) && (q == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int w = 0; w < WHEELS; w++) begin
        nx_q[0][w] <= {side_i[Q_SEL[w]][AB_W-1], side_i[Q_SEL[w]]};
        ny_q[0][w] <= {side_i[P_SEL[w]][AB_W-1], side_i[P_SEL[w]]};
        nm_q[0][w] <= (mag_of(side_i[Q_SEL[w]]) > mag_of(side_i[P_SEL[w]])) ?
                      {1'b0, mag_of(side_i[Q_SEL[w]])} : {1'b0, mag_of(side_i[P_SEL[w]])};
      end
    end
  end

  // leading-zero normalization, one shift weight per stage
  for (genvar n = 1; n <= NORM_N; n++) begin : g_norm
    localparam int SH = 1 << (NORM_N - n);
    always_ff @(posedge clk) begin
      if (en) begin
        for (int w = 0; w < WHEELS; w++) begin
          if ((nm_q[n-1][w] >> (M_W - SH)) == '0) begin
            nx_q[n][w] <= nx_q[n-1][w] << SH;
            ny_q[n][w] <= ny_q[n-1][w] << SH;
            nm_q[n][w] <= nm_q[n-1][w] << SH;
          end else begin
            nx_q[n][w] <= nx_q[n-1][w];
            ny_q[n][w] <= ny_q[n-1][w];
            nm_q[n][w] <= nm_q[n-1][w];
          end
        end
      end
    end
  end

  // fold left half-plane by +-90 degrees
  always_ff @(posedge clk) begin
    logic signed [CX_W-1:0] xv, yv;
    if (en) begin
      for (int w = 0; w < WHEELS; w++) begin
        xv = CX_W'($signed(nx_q[NORM_N][w]));
        yv = CX_W'($signed(ny_q[NORM_N][w]));
        if (xv < 0) begin
          if (yv >= 0) begin
            cx_q[0][w] <= yv;
            cy_q[0][w] <= -xv;
            cz_q[0][w] <= Z_W'(Z_QUARTER);
          end else begin
            cx_q[0][w] <= -yv;
            cy_q[0][w] <= xv;
            cz_q[0][w] <= -Z_W'(Z_QUARTER);
          end
        end else begin
          cx_q[0][w] <= xv;
          cy_q[0][w] <= yv;
          cz_q[0][w] <= '0;
        end
      end
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_iter
    always_ff @(posedge clk) begin
      logic signed [CX_W-1:0] xv, yv, dx, dy;
      logic signed [Z_W-1:0]  zv;
      if (en) begin
        for (int w = 0; w < WHEELS; w++) begin
          xv = $signed(cx_q[i][w]);
          yv = $signed(cy_q[i][w]);
          zv = $signed(cz_q[i][w]);
          dx = yv >>> i;
          dy = xv >>> i;
          if (yv > 0) begin
            cx_q[i+1][w] <= xv + dx;
            cy_q[i+1][w] <= yv - dy;
            cz_q[i+1][w] <= zv + atan_step(i);
          end else begin
            cx_q[i+1][w] <= xv - dx;
            cy_q[i+1][w] <= yv + dy;
            cz_q[i+1][w] <= zv - atan_step(i);
          end
        end
      end
    end
  end

  // round half up to 1/64 degree and clamp
  always_ff @(posedge clk) begin
    logic signed [Z_W-1:0] t;
    if (en) begin
      for (int w = 0; w < WHEELS; w++) begin
        t = ($signed(cz_q[STEPS][w]) + Z_W'(512)) >>> 10;
        if (zero_q[LAT-2][w]) begin
          ang_q[w] <= '0;
        end else if (t > Z_W'(ANGLE_LIMIT)) begin
          ang_q[w] <= ANG_W'(ANGLE_LIMIT);
        end else if (t < -Z_W'(ANGLE_LIMIT)) begin
          ang_q[w] <= ANG_W'(-ANGLE_LIMIT);
        end else begin
          ang_q[w] <= t[ANG_W-1:0];
        end
      end
    end
  end

  assign ctl_o = ctl_q[LAT-1];
  assign spd_o = spd_q[LAT-1];
  assign ang_o = ang_q;

endmodule

FILE: hdl/swk_div.sv
// Speed normalization: max of the four speeds, restoring divide, drive rounding.
// Depends on swk_pkg.
module swk_div import swk_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     en,
  input  ctl_t     ctl_i,
  input  spd_vec_t spd_i,
  input  ang_vec_t ang_i,
  output ctl_t     ctl_o,
  output ang_vec_t ang_o,
  output drv_vec_t drv_o
);

  localparam int QB  = DRV_W + 1;
  localparam int LAT = QB + 3;

  ctl_t                        ctl_q [LAT];
  spd_vec_t                    spd_q [LAT];
  ang_vec_t                    ang_q [LAT];
  logic [1:0][SPD_W-1:0]       half_q;
  logic [SPD_W-1:0]            mx_q;
  logic [SPD_W-1:0]            dm_q [QB];
  spd_vec_t                    dr_q [QB];
  logic [WHEELS-1:0][QB-1:0]   dq_q [QB];
  drv_vec_t                    drv_q;

  for (genvar s = 0; s < LAT; s++) begin : g_pay
    if (s == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (rst) begin
          ctl_q[s] <= '0;
        end else if (en) begin
          ctl_q[s] <= ctl_i;
        end
      end
      always_ff @(posedge clk) begin
        if (en) begin
          spd_q[s] <= spd_i;
          ang_q[s] <= ang_i;
        end
      end
    end else begin : g_rest
      always_ff @(posedge clk) begin
        if (rst) begin
          ctl_q[s] <= '0;
        end else if (en) begin
          ctl_q[s] <= ctl_q[s-1];
        end
      end
      always_ff @(posedge clk) begin
        if (en) begin
          spd_q[s] <= spd_q[s-1];
          ang_q[s] <= ang_q[s-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      half_q[0] <= (spd_i[0] > spd_i[1]) ? spd_i[0] : spd_i[1];
      half_q[1] <= (spd_i[2] > spd_i[3]) ? spd_i[2] : spd_i[3];
      mx_q <= (half_q[0] > half_q[1]) ? half_q[0] : half_q[1];
    end
  end

  for (genvar j = 0; j < QB; j++) begin : g_div
    logic [SPD_W-1:0]          mx_in;
    spd_vec_t                  r_in, r_nx;
    logic [WHEELS-1:0][QB-1:0] q_in, q_nx;
    logic [WHEELS-1:0][SPD_W:0] rt;

    if (j == 0) begin : g_first
      assign mx_in = mx_q;
      assign q_in  = '0;
      always_comb begin
        for (int w = 0; w < WHEELS; w++) begin
          rt[w] = {1'b0, spd_q[1][w]};
        end
      end
      assign r_in = '0;
    end else begin : g_rest
      assign mx_in = dm_q[j-1];
      assign q_in  = dq_q[j-1];
      assign r_in  = dr_q[j-1];
      always_comb begin
        for (int w = 0; w < WHEELS; w++) begin
          rt[w] = {r_in[w], 1'b0};
        end
      end
    end

    always_comb begin
      for (int w = 0; w < WHEELS; w++) begin
        if (rt[w] >= {1'b0, mx_in}) begin
          r_nx[w] = SPD_W'(rt[w] - {1'b0, mx_in});
          q_nx[w] = {q_in[w][QB-2:0], 1'b1};
        end else begin
          r_nx[w] = rt[w][SPD_W-1:0];
          q_nx[w] = {q_in[w][QB-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dm_q[j] <= mx_in;
        dr_q[j] <= r_nx;
        dq_q[j] <= q_nx;
      end
    end
  end

  always_ff @(posedge clk) begin
    logic [QB:0]    qr;
    logic [SPD_W:0] sr;
    if (en) begin
      for (int w = 0; w < WHEELS; w++) begin
        qr = ({1'b0, dq_q[QB-1][w]} + 1'b1) >> 1;
        sr = ({1'b0, spd_q[LAT-2][w]} + (SPD_W+1)'(4096)) >> 13;
        drv_q[w] <= ctl_q[LAT-2].limited ? qr[DRV_W-1:0] : sr[DRV_W-1:0];
      end
    end
  end

  assign ctl_o = ctl_q[LAT-1];
  assign ang_o = ang_q[LAT-1];
  assign drv_o = drv_q;

endmodule

FILE: hdl/swerve_wheel_kinematics.sv
// Top level: configuration registers, kinematics pipeline and output skid stage.
// Depends on swk_pkg, swk_front, swk_sqrt, swk_cordic, swk_div.
//
// Usage:
//   Input beats on s_* carry one motion command (vel_x, vel_y, turn_rate).
//   Output beats on m_* carry four wheel angles, four drive commands and the
//   speeds_limited flag. One output beat per input beat, in order.
//   wheel_base and track_width are written through cfg_we/cfg_addr/cfg_wdata
//   while the pipeline is empty; other addresses are ignored.
//   Throughput: one beat per cycle while no stall holds the pipeline. Latency
//   from input acceptance to m_tvalid is set by the front end, the 32-stage
//   square root, the CORDIC stages and the 16-stage divider in series.
//   Reset: pipeline valid bits and the output stage clear, both config
//   registers return to 1.0 (4096).
//   Stall: when m_tready is low one further beat parks in the skid register,
//   then s_tready drops and the whole pipeline holds; nothing is lost.
module swerve_wheel_kinematics import swk_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [47:0]          s_tdata,   // vel_x, vel_y, turn_rate
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [119:0]         m_tdata,   // angle_bd, angle_bc, angle_ad, angle_ac,
                                          // drive_bd, drive_bc, drive_ad, drive_ac
  output logic                 m_tuser,   // speeds_limited
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  logic [CFG_W-1:0] wheel_base, track_width;
  logic             en;
  ctl_t             f_ctl, s_ctl, c_ctl, d_ctl;
  side_vec_t        f_side, s_side;
  sq_vec_t          f_sq;
  spd_vec_t         s_spd, c_spd;
  ang_vec_t         c_ang, d_ang;
  drv_vec_t         d_drv;
  logic [119:0]     p_data, skid_data;
  logic             skid_user, skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wheel_base <= CFG_W'(CFG_RESET);
      track_width <= CFG_W'(CFG_RESET);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_WHEEL_BASE:  wheel_base <= cfg_wdata;
        REG_TRACK_WIDTH: track_width <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign en = !skid_valid;
  assign s_tready = en;

  swk_front u_front (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(s_tvalid),
    .vel_x($signed(s_tdata[15:0])),
    .vel_y($signed(s_tdata[31:16])),
    .turn_rate($signed(s_tdata[47:32])),
    .wheel_base(wheel_base), .track_width(track_width),
    .ctl_o(f_ctl), .side_o(f_side), .sq_o(f_sq)
  );

  swk_sqrt u_sqrt (
    .clk(clk), .rst(rst), .en(en),
    .ctl_i(f_ctl), .side_i(f_side), .sq_i(f_sq),
    .ctl_o(s_ctl), .side_o(s_side), .spd_o(s_spd)
  );

  swk_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk(clk), .rst(rst), .en(en),
    .ctl_i(s_ctl), .side_i(s_side), .spd_i(s_spd),
    .ctl_o(c_ctl), .spd_o(c_spd), .ang_o(c_ang)
  );

  swk_div u_div (
    .clk(clk), .rst(rst), .en(en),
    .ctl_i(c_ctl), .spd_i(c_spd), .ang_i(c_ang),
    .ctl_o(d_ctl), .ang_o(d_ang), .drv_o(d_drv)
  );

  assign p_data = {d_drv, d_ang};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      if (skid_valid) begin
        m_tvalid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        m_tvalid <= d_ctl.valid;
      end
    end else if (d_ctl.valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!m_tvalid || m_tready) begin
      if (skid_valid) begin
        m_tdata <= skid_data;
        m_tuser <= skid_user;
      end else begin
        m_tdata <= p_data;
        m_tuser <= d_ctl.limited;
      end
    end else if (en) begin
      skid_data <= p_data;
      skid_user <= d_ctl.limited;
    end
  end

endmodule
